// File: rtl/core/lcdseq_pkg.sv
// Shared types, command codes and the power-up byte table for the LCD write sequencer.
package lcdseq_pkg;

    localparam int unsigned QDEPTH = 2;
    localparam int unsigned QAW    = $clog2(QDEPTH);
    localparam int unsigned QCW    = $clog2(QDEPTH + 1);

    localparam logic [1:0] CMD_INS  = 2'd0;
    localparam logic [1:0] CMD_CHR  = 2'd1;
    localparam logic [1:0] CMD_INIT = 2'd2;

    localparam logic CFG_ENABLE_HOLD = 1'b0;
    localparam logic CFG_SETTLE      = 1'b1;

    localparam logic [7:0] ENABLE_HOLD_RST = 8'd1;
    localparam logic [7:0] SETTLE_RST      = 8'd5;

    localparam int unsigned INIT_LEN = 7;
    localparam logic [2:0]  INIT_END = 3'(INIT_LEN);

    typedef enum logic [1:0] {
        K_INS,
        K_CHR,
        K_INIT
    } t_kind;

    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] value;
    } t_in;

    typedef struct packed {
        logic       reg_select;
        logic       read_write;
        logic       enable;
        logic [3:0] data_nibble;
        logic [7:0] hold_ms;
        logic       last;
    } t_out;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] value;
    } t_op;

    function automatic logic [7:0] init_byte(input logic [2:0] idx);
        logic [7:0] b;
        case (idx)
            3'd0:    b = 8'h33;
            3'd1:    b = 8'h32;
            3'd2:    b = 8'h28;
            3'd3:    b = 8'h02;
            3'd4:    b = 8'h0C;
            3'd5:    b = 8'h01;
            3'd6:    b = 8'h06;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

// File: rtl/core/char_lcd_nibble_write_sequencer_core.sv
// Top level of the 4-bit character LCD write sequencer.
// Each transfer in asks for an instruction byte, a character byte or the power-up
// sequence; the block answers with pin states (RS, RW, EN, D7..D4 and a hold time
// in ms) that the next stage plays out on the bus. A byte write gives five pin
// states, one per cycle while the output is not stalled, and the next request is
// taken with the last of them; the power-up sequence gives 36 pin states.
// The back-end sequencer emits one pin state per cycle into its output register
// unless that register is stalled. Requests are decoded in the front end and wait
// in a two-entry queue, so new requests are taken while the sequencer is busy or
// its output is stalled. Unused command code 3 is taken and dropped with no pin
// states. Timing registers: index 0 is the enable high time, index 1 the settle
// time after each byte; write them only while the block is idle.
module char_lcd_nibble_write_sequencer_core
    import lcdseq_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_idx,
    input  logic [7:0] i_cfg_wdata,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  t_in        i_in_data,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output t_out       o_out_data
);

    logic push_valid;
    logic push_ready;
    t_op  push_data;
    logic pop_valid;
    logic pop_ready;
    t_op  pop_data;

    lcdseq_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_in_data    (i_in_data),
        .o_push_valid (push_valid),
        .i_push_ready (push_ready),
        .o_push_data  (push_data)
    );

    lcdseq_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .o_push_ready (push_ready),
        .i_push_data  (push_data),
        .o_pop_valid  (pop_valid),
        .i_pop_ready  (pop_ready),
        .o_pop_data   (pop_data)
    );

    lcdseq_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_pop_valid (pop_valid),
        .o_pop_ready (pop_ready),
        .i_pop_data  (pop_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

// File: rtl/core/lcdseq_front.sv
// Front end: accepts requests, decodes the command and drops unused codes.
module lcdseq_front
    import lcdseq_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in_data,
    output logic o_push_valid,
    input  logic i_push_ready,
    output t_op  o_push_data
);

    logic r_valid;
    t_op  r_op;
    logic cmd_ok;
    t_op  op;

    always_comb begin
        cmd_ok   = 1'b1;
        op.value = i_in_data.value;
        case (i_in_data.cmd)
            CMD_INS:  op.kind = K_INS;
            CMD_CHR:  op.kind = K_CHR;
            CMD_INIT: op.kind = K_INIT;
            default: begin
                op.kind = K_INS;
                cmd_ok  = 1'b0;
            end
        endcase
    end

    assign o_in_ready   = !r_valid || i_push_ready;
    assign o_push_valid = r_valid;
    assign o_push_data  = r_op;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_in_valid && o_in_ready) begin
            r_valid <= cmd_ok;
        end else if (i_push_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_op <= op;
        end
    end

endmodule

// File: rtl/core/lcdseq_queue.sv
// Short queue of decoded requests between front end and sequencer.
module lcdseq_queue
    import lcdseq_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push_valid,
    output logic o_push_ready,
    input  t_op  i_push_data,
    output logic o_pop_valid,
    input  logic i_pop_ready,
    output t_op  o_pop_data
);

    t_op              r_mem [QDEPTH];
    logic [QAW-1:0]   r_wptr;
    logic [QAW-1:0]   r_rptr;
    logic [QCW-1:0]   r_count;
    logic             push;
    logic             pop;

    assign o_push_ready = (r_count != QCW'(QDEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_data   = r_mem[r_rptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (push) begin
                r_wptr <= (r_wptr == QAW'(QDEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (pop) begin
                r_rptr <= (r_rptr == QAW'(QDEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            case ({push, pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wptr] <= i_push_data;
        end
    end

endmodule

// File: rtl/core/lcdseq_back.sv
// Back end: holds timing registers; one pin state per cycle unless stalled.
module lcdseq_back
    import lcdseq_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_idx,
    input  logic [7:0] i_cfg_wdata,
    input  logic       i_pop_valid,
    output logic       o_pop_ready,
    input  t_op        i_pop_data,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output t_out       o_out_data
);

    typedef enum logic [2:0] {
        PH_HI_SETUP,
        PH_HI_STROBE,
        PH_LO_SETUP,
        PH_LO_STROBE,
        PH_SETTLE
    } t_phase;

    logic [7:0] r_enable_hold;
    logic [7:0] r_settle;
    logic       r_busy;
    t_op        r_op;
    t_phase     r_phase;
    logic [2:0] r_idx;
    logic       r_out_valid;
    t_out       r_out;

    t_phase     n_phase;
    logic       can_load;
    logic       step;
    logic       fin;
    logic       init_end;
    logic [7:0] cur_byte;
    t_out       pin;

    assign init_end = (r_op.kind == K_INIT) && (r_idx == INIT_END);
    assign fin      = init_end || ((r_op.kind != K_INIT) && (r_phase == PH_SETTLE));
    assign can_load = !r_out_valid || i_out_ready;
    assign step     = r_busy && can_load;
    assign o_pop_ready = !r_busy || (step && fin);
    assign cur_byte = (r_op.kind == K_INIT) ? init_byte(r_idx) : r_op.value;

    always_comb begin
        pin.reg_select  = (r_op.kind == K_CHR);
        pin.read_write  = 1'b0;
        pin.enable      = 1'b0;
        pin.data_nibble = cur_byte[3:0];
        pin.hold_ms     = 8'd0;
        pin.last        = 1'b0;
        n_phase         = PH_HI_SETUP;
        case (r_phase)
            PH_HI_SETUP: begin
                pin.data_nibble = cur_byte[7:4];
                n_phase         = PH_HI_STROBE;
            end
            PH_HI_STROBE: begin
                pin.data_nibble = cur_byte[7:4];
                pin.enable      = 1'b1;
                pin.hold_ms     = r_enable_hold;
                n_phase         = PH_LO_SETUP;
            end
            PH_LO_SETUP: begin
                n_phase = PH_LO_STROBE;
            end
            PH_LO_STROBE: begin
                pin.enable  = 1'b1;
                pin.hold_ms = r_enable_hold;
                n_phase     = PH_SETTLE;
            end
            PH_SETTLE: begin
                pin.hold_ms = r_settle;
                pin.last    = (r_op.kind != K_INIT);
                n_phase     = PH_HI_SETUP;
            end
            default: begin
                n_phase = PH_HI_SETUP;
            end
        endcase
        if (init_end) begin
            pin = '0;
            pin.last = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable_hold <= ENABLE_HOLD_RST;
            r_settle      <= SETTLE_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_ENABLE_HOLD: r_enable_hold <= i_cfg_wdata;
                CFG_SETTLE:      r_settle      <= i_cfg_wdata;
                default:         r_settle      <= r_settle;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_phase     <= PH_HI_SETUP;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_pop_valid && o_pop_ready) begin
                r_busy  <= 1'b1;
                r_op    <= i_pop_data;
                r_phase <= PH_HI_SETUP;
                r_idx   <= '0;
            end else if (step && fin) begin
                r_busy <= 1'b0;
            end else if (step) begin
                r_phase <= n_phase;
                if (r_phase == PH_SETTLE) begin
                    r_idx <= r_idx + 1'b1;
                end
            end
            if (step) begin
                r_out_valid <= 1'b1;
                r_out       <= pin;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// File: rtl/core/lcdseq_checker.sv
// Port-level checks for the LCD write sequencer, bound to the top level.
module lcdseq_checker
    import lcdseq_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input t_out       o_out_data
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("output transfer changed while stalled");

    a_rw_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.read_write == 1'b0))
        else $error("RW driven high");

    a_strobe_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.enable |-> !o_out_data.last)
        else $error("item ended with EN high");

    a_no_double_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && o_out_data.enable
        |=> !o_out_valid || !o_out_data.enable)
        else $error("two strobe states in a row");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid right after reset");

endmodule

bind char_lcd_nibble_write_sequencer_core lcdseq_checker u_lcdseq_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

// File: tb/sv/tb_char_lcd_nibble_write_sequencer_core.sv
// Self-checking testbench for the 4-bit character LCD write sequencer core.
`timescale 1ns / 100ps

module tb_char_lcd_nibble_write_sequencer_core;
    import lcdseq_pkg::*;

    localparam logic [1:0] CMD_UNUSED      = 2'd3;
    localparam int         DRAIN_CYCLES    = 16;
    localparam int         HOLD_OFF_CYCLES = 200;
    localparam int         N_DIR           = 15;

    localparam logic [7:0] POWER_UP_BYTES [INIT_LEN] = '{
        8'h33, 8'h32, 8'h28, 8'h02, 8'h0C, 8'h01, 8'h06
    };

    typedef struct packed {
        t_in  req;
        logic typed;
        t_out final_state;
    } t_dir_row;

    // typed rows carry the final pin state written out for the reset timing
    localparam t_dir_row DIR_ROWS [N_DIR] = '{
        '{'{CMD_INS,    8'h00}, 1'b1, '{1'b0, 1'b0, 1'b0, 4'h0, 8'd5, 1'b1}},
        '{'{CMD_CHR,    8'hFF}, 1'b1, '{1'b1, 1'b0, 1'b0, 4'hF, 8'd5, 1'b1}},
        '{'{CMD_INS,    8'hFF}, 1'b0, '0},
        '{'{CMD_CHR,    8'h00}, 1'b0, '0},
        '{'{CMD_INS,    8'hF0}, 1'b0, '0},
        '{'{CMD_CHR,    8'h0F}, 1'b0, '0},
        '{'{CMD_INS,    8'hA5}, 1'b0, '0},
        '{'{CMD_CHR,    8'h5A}, 1'b0, '0},
        '{'{CMD_UNUSED, 8'hFF}, 1'b0, '0},
        '{'{CMD_UNUSED, 8'h00}, 1'b0, '0},
        '{'{CMD_INIT,   8'hFF}, 1'b1, '{1'b0, 1'b0, 1'b0, 4'h0, 8'd0, 1'b1}},
        '{'{CMD_CHR,    8'h41}, 1'b0, '0},
        '{'{CMD_UNUSED, 8'h55}, 1'b0, '0},
        '{'{CMD_INIT,   8'h00}, 1'b0, '0},
        '{'{CMD_INS,    8'h01}, 1'b0, '0}
    };

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_cfg_we    = 1'b0;
    logic       i_cfg_idx   = CFG_ENABLE_HOLD;
    logic [7:0] i_cfg_wdata = 8'h00;
    logic       i_in_valid  = 1'b0;
    logic       o_in_ready;
    t_in        i_in_data   = '0;
    logic       o_out_valid;
    logic       i_out_ready = 1'b0;
    t_out       o_out_data;

    logic [7:0] hold_en_ms     = ENABLE_HOLD_RST;
    logic [7:0] hold_settle_ms = SETTLE_RST;
    t_out       pin_state_q [$];
    int         errors        = 0;
    int         send_idle_pct = 0;
    int         rcv_idle_pct  = 0;
    int         hold_off_req  = 0;

    char_lcd_nibble_write_sequencer_core DUT (.*);

    always #2 i_clk = ~i_clk;

    function automatic t_out pin(input logic rs, input logic en, input logic [3:0] nib,
                                 input logic [7:0] hold, input logic fin);
        t_out s;
        s.reg_select  = rs;
        s.read_write  = 1'b0;
        s.enable      = en;
        s.data_nibble = nib;
        s.hold_ms     = hold;
        s.last        = fin;
        return s;
    endfunction

    function automatic void queue_byte(input logic rs, input logic [7:0] b, input logic fin);
        pin_state_q.push_back(pin(rs, 1'b0, b[7:4], 8'd0, 1'b0));
        pin_state_q.push_back(pin(rs, 1'b1, b[7:4], hold_en_ms, 1'b0));
        pin_state_q.push_back(pin(rs, 1'b0, b[3:0], 8'd0, 1'b0));
        pin_state_q.push_back(pin(rs, 1'b1, b[3:0], hold_en_ms, 1'b0));
        pin_state_q.push_back(pin(rs, 1'b0, b[3:0], hold_settle_ms, fin));
    endfunction

    function automatic void predict_pin_states(input t_in r);
        case (r.cmd)
            CMD_INS: queue_byte(1'b0, r.value, 1'b1);
            CMD_CHR: queue_byte(1'b1, r.value, 1'b1);
            CMD_INIT: begin
                foreach (POWER_UP_BYTES[i]) queue_byte(1'b0, POWER_UP_BYTES[i], 1'b0);
                pin_state_q.push_back(pin(1'b0, 1'b0, 4'h0, 8'd0, 1'b1));
            end
            default: ;
        endcase
    endfunction

    function automatic t_in random_request();
        t_in r;
        int  pick;
        pick    = $urandom_range(99);
        r.value = 8'($urandom);
        if (pick < 4)       r.cmd = CMD_INIT;
        else if (pick < 10) r.cmd = CMD_UNUSED;
        else if (pick < 55) r.cmd = CMD_INS;
        else                r.cmd = CMD_CHR;
        return r;
    endfunction

    task automatic send_request(input t_in r, input logic typed = 1'b0,
                                input t_out final_state = '0);
        while (int'($urandom_range(99)) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= r;
        do @(posedge i_clk); while (!o_in_ready);
        predict_pin_states(r);
        if (typed) pin_state_q[pin_state_q.size() - 1] = final_state;
    endtask

    task automatic run_random(input int n_items);
        t_in r;
        int  sent;
        sent = 0;
        while (sent < n_items) begin
            r = random_request();
            send_request(r);
            if (r.cmd != CMD_UNUSED) sent++;
        end
    endtask

    // dropped commands leave no pin state behind, so give the pipe time to empty
    task automatic drain();
        i_in_valid <= 1'b0;
        while (pin_state_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_timing(input logic [7:0] en_ms, input logic [7:0] settle);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= CFG_ENABLE_HOLD;
        i_cfg_wdata <= en_ms;
        @(posedge i_clk);
        i_cfg_idx   <= CFG_SETTLE;
        i_cfg_wdata <= settle;
        @(posedge i_clk);
        i_cfg_we       <= 1'b0;
        hold_en_ms     = en_ms;
        hold_settle_ms = settle;
    endtask

    task automatic check_field(input string name, input logic [7:0] want_v,
                               input logic [7:0] got_v);
        if (want_v !== got_v) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want_v, got_v);
            errors++;
        end
    endtask

    task automatic check_pin_state(input t_out got);
        t_out want;
        if (pin_state_q.size() == 0) begin
            $display("%0t: unexpected pin state transfer, expected none, actual %h",
                     $time, got);
            errors++;
            return;
        end
        want = pin_state_q.pop_front();
        check_field("reg_select",  8'(want.reg_select),  8'(got.reg_select));
        check_field("read_write",  8'(want.read_write),  8'(got.read_write));
        check_field("enable",      8'(want.enable),      8'(got.enable));
        check_field("data_nibble", 8'(want.data_nibble), 8'(got.data_nibble));
        check_field("hold_ms",     want.hold_ms,         got.hold_ms);
        check_field("last",        8'(want.last),        8'(got.last));
    endtask

    initial begin
        int hold_off_left;
        int hold_off_seen;
        hold_off_left = 0;
        hold_off_seen = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && i_out_ready) check_pin_state(o_out_data);
            if (hold_off_seen != hold_off_req) begin
                hold_off_seen = hold_off_req;
                hold_off_left = HOLD_OFF_CYCLES;
            end
            if (hold_off_left > 0) begin
                hold_off_left--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= (int'($urandom_range(99)) >= rcv_idle_pct);
            end
        end
    end

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_idle_pct = 30;
        rcv_idle_pct  = 46;
        foreach (DIR_ROWS[k])
            send_request(DIR_ROWS[k].req, DIR_ROWS[k].typed, DIR_ROWS[k].final_state);
        drain();

        set_timing(8'h00, 8'h00);
        run_random(30);
        drain();

        send_idle_pct = 46;
        rcv_idle_pct  = 30;
        set_timing(8'hFF, 8'hFF);
        run_random(30);
        drain();

        // receiver stalls long while requests keep coming, filling the queue
        send_idle_pct = 0;
        rcv_idle_pct  = 0;
        set_timing(8'($urandom), 8'($urandom));
        hold_off_req++;
        run_random(30);
        drain();

        if (errors == 0)
            $display("** char_lcd_nibble_write_sequencer_core: PASSED **");
        else
            $display("** char_lcd_nibble_write_sequencer_core: FAILED **");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("** char_lcd_nibble_write_sequencer_core: FAILED **");
        $finish;
    end

endmodule
